// ===== rtl/ism_pkg.sv =====
// Shared constants and types for the interval sort and merge block.
`default_nettype none
package ism_pkg;
  localparam int MaxSegments = 64;
  localparam int IdxW = $clog2(MaxSegments);
  localparam int CntW = $clog2(MaxSegments + 1);
  localparam int PAddrW = 3;
  localparam logic [PAddrW-1:0] RegMergeGap = 3'd0;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] start;
    logic [15:0] stop;
  } seg_t;

  // word handed from loader to sorter/merger: one closed set
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            ovf;
  } set_t;
endpackage
`default_nettype wire

// ===== rtl/interval_sort_and_merge_top.sv =====
// Top level: APB register, front loader, back sort/merge engine.
//  channel | signals                                   | role
//  in      | in_valid/in_ready, line_tag..final_item   | segment words
//  out     | out_valid/out_ready, out_line_tag..overflowed | merged words
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata   | merge_gap at 0x0
// Loading takes one word per cycle; input stalls from set close until the
// engine has placed the last merged word in its output register. The insertion
// sort shifts entries one slot per step through the single store write port
// (O(n^2)); merging reads each sorted entry, then emits each merged word.
// Reset is synchronous and clears control and merge_gap; the store is not cleared.
`default_nettype none
module interval_sort_and_merge_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [15:0] line_tag,
  input  wire  [15:0] seg_start,
  input  wire  [15:0] seg_end,
  input  wire         final_item,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [15:0] out_line_tag,
  output logic [15:0] out_start,
  output logic [15:0] out_end,
  output logic        out_final,
  output logic        overflowed,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [ism_pkg::PAddrW-1:0] paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ism_pkg::*;

  logic [15:0]     merge_gap;
  logic            wr_en, set_valid, set_ready;
  logic [IdxW-1:0] wr_addr;
  seg_t            wr_data, in_seg, out_seg;
  set_t            set_word;

  assign pready = 1'b1;
  assign in_seg = '{tag: line_tag, start: seg_start, stop: seg_end};

  // register write and read
  always_ff @(posedge clk) begin
    if (rst) merge_gap <= '0;
    else if (psel && penable && pwrite && paddr == RegMergeGap) merge_gap <= pwdata[15:0];
  end
  assign prdata = (paddr == RegMergeGap) ? {16'd0, merge_gap} : 32'd0;

  ism_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_seg, .in_final(final_item),
    .wr_en, .wr_addr, .wr_data, .set_valid, .set_ready, .set_word
  );

  ism_back u_back (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .set_valid, .set_ready, .set_word,
    .merge_gap, .out_valid, .out_ready, .out_seg, .out_final, .out_ovf(overflowed)
  );

  assign out_line_tag = out_seg.tag;
  assign out_start    = out_seg.start;
  assign out_end      = out_seg.stop;

  // once a closed set is taken, the engine stops accepting sets
  a_set_idle: assert property (@(posedge clk) disable iff (rst)
    set_valid && set_ready |=> !set_ready) else $error("set handoff");
  // no loading while a set waits for the engine
  a_no_load: assert property (@(posedge clk) disable iff (rst)
    set_valid |-> !in_ready) else $error("load during pending set");
  // a stalled result word stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_start)) else $error("out dropped");
endmodule
`default_nettype wire

// ===== rtl/ism_front.sv =====
// Front end: accepts segment words, writes the store, closes sets into a single-entry hold register.
`default_nettype none
module ism_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  ism_pkg::seg_t  in_seg,
  input  wire                  in_final,
  output logic                 wr_en,
  output logic [ism_pkg::IdxW-1:0] wr_addr,
  output ism_pkg::seg_t        wr_data,
  output logic                 set_valid,
  input  wire                  set_ready,
  output ism_pkg::set_t        set_word
);
  import ism_pkg::*;

  logic [CntW-1:0] count;
  logic            ovf;
  logic            busy;
  logic            set_full;
  logic            acc;

  // One set may be in the store at a time; loading stops once a set closes
  // until the back end has drained it.
  assign in_ready  = !busy && !set_full;
  assign acc       = in_valid && in_ready;
  assign wr_en     = acc && (count < CntW'(MaxSegments));
  assign wr_addr   = count[IdxW-1:0];
  assign wr_data   = in_seg;
  assign set_valid = set_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf      <= 1'b0;
      set_full <= 1'b0;
      busy     <= 1'b0;
    end else begin
      if (set_full && set_ready) begin
        set_full <= 1'b0;
        busy     <= 1'b1;
      end
      if (acc) begin
        if (in_final) begin
          set_word.count <= wr_en ? count + 1'b1 : count;
          set_word.ovf   <= ovf || !wr_en;
          set_full       <= 1'b1;
          count          <= '0;
          ovf            <= 1'b0;
        end else begin
          if (wr_en) count <= count + 1'b1;
          else ovf <= 1'b1;
        end
      end
      if (busy && set_ready && !set_full) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ism_back.sv =====
// Back end: stable insertion sort in the store, then merge walk and result output.
`default_nettype none
module ism_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  wr_en,
  input  wire  [ism_pkg::IdxW-1:0] wr_addr,
  input  wire  ism_pkg::seg_t  wr_data,
  input  wire                  set_valid,
  output logic                 set_ready,
  input  wire  ism_pkg::set_t  set_word,
  input  wire  [15:0]          merge_gap,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ism_pkg::seg_t        out_seg,
  output logic                 out_final,
  output logic                 out_ovf
);
  import ism_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDI   = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_MRD   = 3'd3;
  localparam logic [2:0] S_MRG   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_LAST  = 3'd6;

  logic [2:0]      state;
  seg_t            mem [MaxSegments];
  seg_t            rd_data;
  logic [IdxW-1:0] rd_addr;
  logic            mwr;
  logic [IdxW-1:0] maddr;
  seg_t            mdata;
  logic [CntW-1:0] n, i, j;
  logic            ovf;
  seg_t            item, cur;
  logic            first;
  logic [16:0]     reach;

  assign reach     = {1'b0, cur.stop} + {1'b0, merge_gap};
  assign set_ready = (state == S_IDLE);

  // Store: one write port (loader or sort shift), one registered read port
  always_ff @(posedge clk) begin
    if (mwr) mem[maddr] <= mdata;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    mwr = wr_en; maddr = wr_addr; mdata = wr_data;
    if (state == S_CMP) begin
      mwr   = 1'b1;
      mdata = (j != '0 && rd_data.start > item.start) ? rd_data : item;
      maddr = j[IdxW-1:0];
    end
  end

  // first RDI cycle fetches store[i], second fetches store[j-1]
  always_comb begin
    rd_addr = i[IdxW-1:0];
    if (state == S_CMP) rd_addr = j[IdxW-1:0] - 2'd2;
    else if (state == S_RDI && !first && j != '0) rd_addr = j[IdxW-1:0] - 1'b1;
  end

  // Sort: for each i, hold item, shift larger predecessors up one slot.
  // Merge: walk sorted entries, emit when a gap opens and once more at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT && state != S_LAST)
        out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (set_valid) begin
          n   <= set_word.count;
          ovf <= set_word.ovf;
          i   <= '0;
          if (set_word.count != '0) state <= S_RDI;
          first <= 1'b1;
        end
        S_RDI: begin
          // first cycle: j takes i; second cycle: rd_data holds store[i]
          if (first) begin
            first <= 1'b0;
            j     <= i;
          end else begin
            item  <= rd_data;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          // rd_data holds store[j-1]
          if (j != '0 && rd_data.start > item.start) begin
            j <= j - 1'b1;
          end else begin
            if (i + 1'b1 == n) begin
              i <= '0; state <= S_MRD; first <= 1'b1;
            end else begin
              i <= i + 1'b1; state <= S_RDI; first <= 1'b1;
            end
          end
        end
        S_MRD: begin
          if (first) first <= 1'b0;
          else begin
            cur   <= rd_data;
            i     <= i + 1'b1;
            first <= 1'b1;
            state <= (i + 1'b1 == n) ? S_LAST : S_MRG;
          end
        end
        S_MRG: begin
          if (first) first <= 1'b0;
          else if ({1'b0, rd_data.start} <= reach) begin
            if (rd_data.stop > cur.stop) cur.stop <= rd_data.stop;
            i <= i + 1'b1; first <= 1'b1;
            if (i + 1'b1 == n) state <= S_LAST;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1; out_seg <= cur; out_final <= 1'b0; out_ovf <= ovf;
          cur <= rd_data;
          i <= i + 1'b1; first <= 1'b1;
          state <= (i + 1'b1 == n) ? S_LAST : S_MRG;
        end
        S_LAST: if (!out_valid || out_ready) begin
          out_valid <= 1'b1; out_seg <= cur; out_final <= 1'b1; out_ovf <= ovf;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
